FILE: sv/additive_sine_bank_oscillator_defines.svh
// Assertion macros for the additive sine bank oscillator.
// Included by files that carry concurrent checks; depends on a clk and rst_n in scope.
`ifndef ADDITIVE_SINE_BANK_OSCILLATOR_DEFINES_SVH
`define ADDITIVE_SINE_BANK_OSCILLATOR_DEFINES_SVH

// Check that holds only out of reset.
`define ASBO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define ASBO_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/asbo_pkg.sv
// Shared types and constants of the additive sine bank oscillator.
// No dependencies; imported by the top level.
package asbo_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_RATIO  = 2'd1,
        CMD_AMP    = 2'd2,
        CMD_PHASE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_PARTIAL_COUNT = 2'd0,
        REG_STEP_SCALE    = 2'd1,
        REG_COUNT_RECIP   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MUL,
        ST_SAT
    } state_t;

    localparam logic signed [15:0] DEFAULT_AMP      = 16'sd16384;
    localparam logic [6:0]         RST_PARTIALS     = 7'd1;
    localparam logic [23:0]        RST_STEP_SCALE   = 24'd357913;
    localparam logic [16:0]        RST_COUNT_RECIP  = 17'd65536;
    localparam longint unsigned    HALF_PI_Q30      = 64'd1686629713;
    localparam longint unsigned    Q30_ONE          = 64'd1073741824;

    // Taylor series divisors (2k)(2k+1) for k = 1..7
    localparam longint unsigned    TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                        64'd110, 64'd156, 64'd210};

endpackage

FILE: sv/additive_sine_bank_oscillator.sv
// Additive sine bank oscillator: partial state in two memories, sine ROM, MAC pipeline.
// Depends on asbo_pkg and additive_sine_bank_oscillator_defines.svh.
//
// Usage:
//   s_axis carries one command per transfer: tuser selects sample, ratio load,
//   amplitude load or phase load. A sample transfer yields exactly one m_axis
//   transfer; loads yield none.
//   A sample walks the active partials one per cycle: each cycle issues one read
//   of the phase and parameter memories, the sine ROM, interpolation, amplitude
//   multiply and accumulate follow in a five stage pipeline, and the new phase
//   is written back. Partials issue one after another, as the partial memories
//   have a single read port; a sample with non-positive frequency or no
//   partials skips the run and goes straight to the final scale.
//   One item is in work at a time; s_axis_tready is high between items.
//   The result sits in an output register; a stalled receiver holds it there
//   and the next sample waits at its final stage until the register is free.
//   Reset clears the configuration to its defaults and marks every partial
//   entry unwritten, so it reads as phase 0, ratio 0 and amplitude 1.0.
//   TABLE_LEN must be a power of two.
`include "additive_sine_bank_oscillator_defines.svh"

module additive_sine_bank_oscillator
    import asbo_pkg::*;
#(
    parameter int PARTIALS  = 64,
    parameter int TABLE_LEN = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: freq[23:0], partial_index[29:24], ratio[53:30], amplitude[69:54],
    //        start_phase[85:70], zero pad[87:86]
    input  logic [87:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    // sample stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample[17:0], zero pad[23:18]
    output logic [23:0] m_axis_tdata
);

    localparam int LOG2   = $clog2(TABLE_LEN);
    localparam int PW     = LOG2 + 16;
    localparam int AW     = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int CW     = $clog2(PARTIALS + 1);
    localparam int ACC_W  = 33 + CW;
    localparam int FIN_W  = ACC_W + 18;
    localparam logic signed [FIN_W-32:0] SAT_HI = (FIN_W-31)'(131071);
    localparam logic signed [FIN_W-32:0] SAT_LO = -(FIN_W-31)'(131072);

    typedef logic signed [15:0] rom_t [TABLE_LEN];

    // Build one sine cycle with integer arithmetic at elaboration
    function automatic rom_t build_rom();
        rom_t            r;
        longint unsigned p, q, rr, x, x2, term, sum;
        int              v;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            p  = (longint'(i) << 32) / TABLE_LEN;
            q  = (p >> 30) & 64'd3;
            rr = p & (Q30_ONE - 64'd1);
            if (q[0])
                rr = Q30_ONE - rr;
            x    = (rr * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k % 2 == 1)
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            if (sum > Q30_ONE)
                sum = Q30_ONE;
            v    = int'((sum * 64'd32767 + (Q30_ONE >> 1)) >> 30);
            r[i] = (q >= 64'd2) ? 16'(-v) : 16'(v);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic                cmd_in;
    logic        [1:0]   cmd;
    logic signed [23:0]  freq_in;
    logic        [5:0]   pidx_in;
    logic        [23:0]  ratio_in;
    logic        [15:0]  amp_in;
    logic        [15:0]  sphase_in;
    logic                in_xfer;
    logic                idx_ok;
    logic        [AW-1:0] ld_addr;

    assign cmd       = s_axis_tuser;
    assign freq_in   = s_axis_tdata[23:0];
    assign pidx_in   = s_axis_tdata[29:24];
    assign ratio_in  = s_axis_tdata[53:30];
    assign amp_in    = s_axis_tdata[69:54];
    assign sphase_in = s_axis_tdata[85:70];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign cmd_in    = in_xfer && (cmd != CMD_SAMPLE);
    assign idx_ok    = (32'(pidx_in) < PARTIALS);
    assign ld_addr   = AW'(pidx_in);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  pcount_reg;
    logic [23:0] scale_reg;
    logic [16:0] recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= RST_PARTIALS;
            scale_reg  <= RST_STEP_SCALE;
            recip_reg  <= RST_COUNT_RECIP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PARTIAL_COUNT: pcount_reg <= cfg_data[6:0];
                REG_STEP_SCALE:    scale_reg  <= cfg_data;
                REG_COUNT_RECIP:   recip_reg  <= cfg_data[16:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t         state_reg, state_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  n_eff;
    logic [22:0]    freq_reg;
    logic           issue;
    logic           pipe_busy;
    logic           out_load;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic           out_vld_reg;

    assign n_eff = (32'(pcount_reg) > PARTIALS) ? CW'(PARTIALS) : CW'(pcount_reg);
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // Sequence one item: issue partials, drain, scale, saturate
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        issue         = 1'b0;
        out_load      = 1'b0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && cmd == CMD_SAMPLE)
                begin
                    k_next = '0;
                    n_next = n_eff;
                    if (!freq_in[23] && freq_in != 24'sd0 && n_eff != '0)
                        state_next = ST_RUN;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_RUN:
            begin
                issue  = 1'b1;
                k_next = k_reg + CW'(1);
                if (k_next == n_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    // Hold the positive frequency for the run
    always_ff @(posedge clk)
    begin
        if (in_xfer && cmd == CMD_SAMPLE)
            freq_reg <= freq_in[22:0];
    end

    // ------------------------------------------------------------------
    // Partial memories and valid bits
    // ------------------------------------------------------------------
    logic [39:0]         prm_mem [PARTIALS];
    logic [PW-1:0]       ph_mem  [PARTIALS];
    logic [PARTIALS-1:0] ph_vld_reg, ratio_vld_reg, amp_vld_reg;
    logic [AW-1:0]       rd_addr;
    logic [39:0]         prm_rd_reg;
    logic [PW-1:0]       ph_rd_reg;
    logic                ph_vq_reg, ratio_vq_reg, amp_vq_reg;
    logic                ph_we;
    logic [AW-1:0]       ph_wa;
    logic [PW-1:0]       ph_wd;
    logic [AW-1:0]       k3_reg;
    logic [PW-1:0]       ph_new;

    assign rd_addr = k_reg[AW-1:0];

    // Phase write port: loads in idle, write-back from the pipeline otherwise
    always_comb
    begin
        if (v3_reg)
        begin
            ph_we = 1'b1;
            ph_wa = k3_reg;
            ph_wd = ph_new;
        end
        else
        begin
            ph_we = cmd_in && cmd == CMD_PHASE && idx_ok;
            ph_wa = ld_addr;
            ph_wd = PW'(sphase_in) << LOG2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in && idx_ok && cmd == CMD_RATIO)
            prm_mem[ld_addr][39:16] <= ratio_in;
        if (cmd_in && idx_ok && cmd == CMD_AMP)
            prm_mem[ld_addr][15:0] <= amp_in;
        if (ph_we)
            ph_mem[ph_wa] <= ph_wd;
        prm_rd_reg <= prm_mem[rd_addr];
        ph_rd_reg  <= ph_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_vld_reg    <= '0;
            ratio_vld_reg <= '0;
            amp_vld_reg   <= '0;
            ph_vq_reg     <= 1'b0;
            ratio_vq_reg  <= 1'b0;
            amp_vq_reg    <= 1'b0;
        end
        else
        begin
            if (ph_we)
                ph_vld_reg[ph_wa] <= 1'b1;
            if (cmd_in && idx_ok && cmd == CMD_RATIO)
                ratio_vld_reg[ld_addr] <= 1'b1;
            if (cmd_in && idx_ok && cmd == CMD_AMP)
                amp_vld_reg[ld_addr] <= 1'b1;
            ph_vq_reg    <= ph_vld_reg[rd_addr];
            ratio_vq_reg <= ratio_vld_reg[rd_addr];
            amp_vq_reg   <= amp_vld_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Partial pipeline
    // ------------------------------------------------------------------
    logic        [AW-1:0] k1_reg, k2_reg;
    logic        [PW-1:0] ph1, ph2_reg, ph3_reg;
    logic signed [23:0]   ratio1;
    logic        [23:0]   rabs1;
    logic signed [15:0]   amp1, amp2_reg, amp3_reg;
    logic        [LOG2-1:0] idx1, nxt1;
    logic signed [15:0]   ya_reg, yb_reg, ya3_reg;
    logic        [15:0]   frac2_reg;
    logic        [46:0]   mag_reg;
    logic                 neg2_reg, neg3_reg;
    logic signed [33:0]   dprod_reg;
    logic        [47:0]   a_reg;
    logic        [46:0]   b_reg;
    logic signed [17:0]   sine3;
    logic        [48:0]   inc_sum;
    logic        [PW-1:0] inc3;
    logic signed [32:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [FIN_W-1:0] fin_reg;
    logic signed [FIN_W-32:0] res;

    // Stage 1: apply reset values to unwritten entries, address the ROM
    assign ph1    = ph_vq_reg ? ph_rd_reg : '0;
    assign ratio1 = ratio_vq_reg ? prm_rd_reg[39:16] : 24'sd0;
    assign amp1   = amp_vq_reg ? prm_rd_reg[15:0] : DEFAULT_AMP;
    assign idx1   = ph1[PW-1:16];
    assign nxt1   = idx1 + LOG2'(1);
    assign rabs1  = ratio1[23] ? 24'(-ratio1) : 24'(ratio1);

    // Stage 3: interpolated sine and the wrapped phase increment
    assign sine3   = 18'(ya3_reg) + 18'(dprod_reg >>> 16);
    assign inc_sum = 49'(a_reg) + 49'(b_reg >> 23);
    assign inc3    = inc_sum[PW+8:9];
    assign ph_new  = neg3_reg ? ph3_reg - inc3 : ph3_reg + inc3;

    always_ff @(posedge clk)
    begin
        // stage 1 -> 2
        ya_reg    <= SINE_ROM[idx1];
        yb_reg    <= SINE_ROM[nxt1];
        frac2_reg <= ph1[15:0];
        mag_reg   <= 47'(rabs1 * freq_reg);
        neg2_reg  <= ratio1[23];
        ph2_reg   <= ph1;
        amp2_reg  <= amp1;
        k2_reg    <= k1_reg;
        // stage 2 -> 3
        dprod_reg <= 34'((17'(yb_reg) - 17'(ya_reg)) * $signed({1'b0, frac2_reg}));
        ya3_reg   <= ya_reg;
        a_reg     <= mag_reg[46:23] * scale_reg;
        b_reg     <= 47'(mag_reg[22:0] * scale_reg);
        neg3_reg  <= neg2_reg;
        ph3_reg   <= ph2_reg;
        amp3_reg  <= amp2_reg;
        k3_reg    <= k2_reg;
        // stage 3 -> 4
        prod_reg  <= 33'($signed(sine3[16:0]) * amp3_reg);
        // issue -> stage 1
        k1_reg    <= rd_addr;
    end

    // Valid bits of the stages, accumulator, final scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            acc_reg <= '0;
            fin_reg <= '0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (in_xfer && cmd == CMD_SAMPLE)
                acc_reg <= '0;
            else if (v4_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            if (state_reg == ST_MUL)
                fin_reg <= FIN_W'(acc_reg * $signed({1'b0, recip_reg}))
                           + (FIN_W'(1) <<< 30);
        end
    end

    // Round and saturate into the output register
    assign res = fin_reg[FIN_W-1:31];

    logic signed [17:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (res > SAT_HI)
                out_reg <= 18'sd131071;
            else if (res < SAT_LO)
                out_reg <= -18'sd131072;
            else
                out_reg <= res[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, out_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASBO_ASSERT_ALL(a_idle_pipe_empty, (state_reg == ST_IDLE) |-> !pipe_busy, "partial pipeline busy in idle")
    `ASBO_ASSERT_ALL(a_issue_bound, k_reg <= n_reg, "issue counter beyond partial count")
    `ASBO_ASSERT_RST(a_out_hold, (state_reg == ST_SAT && out_vld_reg && !m_axis_tready) |=> (state_reg == ST_SAT), "pending sample overwritten")

endmodule
